[src/tpbfl_pkg.sv]
`default_nettype none

package tpbfl_pkg;

  // Field widths of the stream items and registers
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PSIZE_W   = 19;
  localparam int unsigned ISIZE_W   = 25;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IN_W      = 40;
  localparam int unsigned OUT_W     = 64;

  // Register reset values
  localparam logic [ADDR_W-1:0]  RST_POWER_START = '0;
  localparam logic [PSIZE_W-1:0] RST_POWER_SIZE  = PSIZE_W'(256 * 1024);
  localparam logic [COUNT_W-1:0] RST_POWER_COUNT = COUNT_W'(64);
  localparam logic [ADDR_W-1:0]  RST_INST_START  = '0;
  localparam logic [ISIZE_W-1:0] RST_INST_SIZE   = ISIZE_W'(65536);
  localparam logic [COUNT_W-1:0] RST_INST_COUNT  = COUNT_W'(64);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT        = 2'd0,
    ACT_ALLOC_POWER = 2'd1,
    ACT_ALLOC_INST  = 2'd2,
    ACT_FREE        = 2'd3
  } tpbfl_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_FULL     = 2'd3
  } tpbfl_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_START = 3'd0,
    REG_POWER_SIZE  = 3'd1,
    REG_POWER_COUNT = 3'd2,
    REG_INST_START  = 3'd3,
    REG_INST_SIZE   = 3'd4,
    REG_INST_COUNT  = 3'd5
  } tpbfl_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP,
    ST_FREE_WAIT,
    ST_FREE_CHECK
  } tpbfl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic init_step;
    logic load_init;
    logic load_pop;
    logic load_free;
  } tpbfl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic init_done;
  } tpbfl_stat_t;

endpackage

`default_nettype wire

[src/tpbfl_ctrl.sv]
`default_nettype none

module tpbfl_ctrl
  import tpbfl_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  tpbfl_action_e action_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  input  tpbfl_stat_t   stat_i,
  output tpbfl_cmd_t    cmd_o
);

  tpbfl_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (action_i)
            ACT_INIT:        state_d = ST_INIT;
            ACT_ALLOC_POWER: state_d = ST_POP;
            ACT_ALLOC_INST:  state_d = ST_POP;
            ACT_FREE:        state_d = ST_FREE_WAIT;
            default:         state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        if (!stat_i.init_done) begin
          cmd_o.init_step = 1'b1;
        end else if (out_free) begin
          cmd_o.load_init = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          cmd_o.load_pop = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FREE_WAIT: begin
        // let the pool end addresses settle
        state_d = ST_FREE_CHECK;
      end
      ST_FREE_CHECK: begin
        if (out_free) begin
          cmd_o.load_free = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A result is loaded only when the output slot is free
  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_init || cmd_o.load_pop || cmd_o.load_free) |-> out_free)
    else $error("result loaded into a busy output slot");

  // Output valid rises only after a load
  a_valid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load_init || cmd_o.load_pop || cmd_o.load_free))
    else $error("output valid without a result load");

  // Init walk never steps once done
  a_init_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init_step |-> (state_q == ST_INIT) && !stat_i.init_done)
    else $error("init step outside an active walk");

endmodule

`default_nettype wire

[src/tpbfl_datapath.sv]
`default_nettype none

module tpbfl_datapath
  import tpbfl_pkg::*;
#(
  parameter int unsigned POWER_DEPTH = 64,
  parameter int unsigned INST_DEPTH  = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  tpbfl_action_e        action_i,
  input  wire [ADDR_W-1:0]     address_i,
  input  tpbfl_cmd_t           cmd_i,
  output tpbfl_stat_t          stat_o,
  output tpbfl_status_e        status_o,
  output logic [ADDR_W-1:0]    block_address_o,
  output logic [ISIZE_W-1:0]   alloc_size_o,
  output logic                 pool_o
);

  localparam int unsigned PPW  = (POWER_DEPTH > 1) ? $clog2(POWER_DEPTH) : 1;
  localparam int unsigned IPW  = (INST_DEPTH > 1) ? $clog2(INST_DEPTH) : 1;
  localparam int unsigned PFW  = $clog2(POWER_DEPTH + 1);
  localparam int unsigned IFW  = $clog2(INST_DEPTH + 1);
  localparam int unsigned MAXD = (POWER_DEPTH > INST_DEPTH) ? POWER_DEPTH : INST_DEPTH;
  localparam int unsigned IDXW = $clog2(MAXD + 1);
  localparam int unsigned PPRW = COUNT_W + PSIZE_W;
  localparam int unsigned IPRW = COUNT_W + ISIZE_W;

  // Configuration registers
  logic [ADDR_W-1:0]  p_start_q, i_start_q;
  logic [PSIZE_W-1:0] p_size_q;
  logic [ISIZE_W-1:0] i_size_q;
  logic [COUNT_W-1:0] p_count_q, i_count_q;

  // Pool end pipeline
  logic [PPRW-1:0]    p_prod_q;
  logic [IPRW-1:0]    i_prod_q;
  logic [ADDR_W:0]    p_end_q, i_end_q;

  // Item and init walk
  tpbfl_action_e      action_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [IDXW-1:0]    idx_q;
  logic [ADDR_W-1:0]  p_ia_q, i_ia_q;

  // Free lists
  logic [ADDR_W-1:0]  p_mem [POWER_DEPTH];
  logic [ADDR_W-1:0]  i_mem [INST_DEPTH];
  logic [ADDR_W-1:0]  p_rd_q, i_rd_q;
  logic [PPW-1:0]     p_head_q;
  logic [IPW-1:0]     i_head_q;
  logic [PFW-1:0]     p_fill_q;
  logic [IFW-1:0]     i_fill_q;

  // Output register
  tpbfl_status_e      status_q;
  logic [ADDR_W-1:0]  baddr_q;
  logic [ISIZE_W-1:0] size_q;
  logic               pool_q;

  logic [PFW-1:0]     p_n;
  logic [IFW-1:0]     i_n;
  logic               p_init_wr, i_init_wr;
  logic               in_p, in_i, push_p, push_i;
  logic [PPW:0]       p_tsum;
  logic [IPW:0]       i_tsum;
  logic [PPW-1:0]     p_tail, p_head_inc;
  logic [IPW-1:0]     i_tail, i_head_inc;
  logic               pop_inst, pop_ok;
  logic               p_we, i_we;
  logic [PPW-1:0]     p_waddr;
  logic [IPW-1:0]     i_waddr;
  logic [ADDR_W-1:0]  p_wdata, i_wdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_start_q <= RST_POWER_START;
      p_size_q  <= RST_POWER_SIZE;
      p_count_q <= RST_POWER_COUNT;
      i_start_q <= RST_INST_START;
      i_size_q  <= RST_INST_SIZE;
      i_count_q <= RST_INST_COUNT;
    end else if (cfg_we_i) begin
      unique case (tpbfl_reg_e'(cfg_idx_i))
        REG_POWER_START: p_start_q <= cfg_data_i[ADDR_W-1:0];
        REG_POWER_SIZE:  p_size_q  <= cfg_data_i[PSIZE_W-1:0];
        REG_POWER_COUNT: p_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_INST_START:  i_start_q <= cfg_data_i[ADDR_W-1:0];
        REG_INST_SIZE:   i_size_q  <= cfg_data_i[ISIZE_W-1:0];
        REG_INST_COUNT:  i_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Track pool end addresses: multiply, then add
  always_ff @(posedge clk_i) begin
    p_prod_q <= PPRW'(p_count_q) * PPRW'(p_size_q);
    i_prod_q <= IPRW'(i_count_q) * IPRW'(i_size_q);
    p_end_q  <= {1'b0, p_start_q} + (ADDR_W+1)'(p_prod_q);
    i_end_q  <= {1'b0, i_start_q} + (ADDR_W+1)'(i_prod_q);
  end

  // Number of addresses an init stores per pool
  assign p_n = (32'(p_count_q) > 32'(POWER_DEPTH)) ? PFW'(POWER_DEPTH) : PFW'(p_count_q);
  assign i_n = (32'(i_count_q) > 32'(INST_DEPTH)) ? IFW'(INST_DEPTH) : IFW'(i_count_q);
  assign p_init_wr = 32'(idx_q) < 32'(p_n);
  assign i_init_wr = 32'(idx_q) < 32'(i_n);
  assign stat_o.init_done = !p_init_wr && !i_init_wr;

  // Range test, power pool first
  assign in_p   = (addr_q >= p_start_q) && ({1'b0, addr_q} < p_end_q);
  assign in_i   = (addr_q >= i_start_q) && ({1'b0, addr_q} < i_end_q);
  assign push_p = in_p && (32'(p_fill_q) < 32'(POWER_DEPTH));
  assign push_i = !in_p && in_i && (32'(i_fill_q) < 32'(INST_DEPTH));

  // Tail index: head plus fill, wrapped once
  assign p_tsum = (PPW+1)'(p_head_q) + (PPW+1)'(p_fill_q);
  assign i_tsum = (IPW+1)'(i_head_q) + (IPW+1)'(i_fill_q);
  assign p_tail = (p_tsum >= (PPW+1)'(POWER_DEPTH)) ?
                  PPW'(p_tsum - (PPW+1)'(POWER_DEPTH)) : PPW'(p_tsum);
  assign i_tail = (i_tsum >= (IPW+1)'(INST_DEPTH)) ?
                  IPW'(i_tsum - (IPW+1)'(INST_DEPTH)) : IPW'(i_tsum);
  assign p_head_inc = (32'(p_head_q) == 32'(POWER_DEPTH - 1)) ? '0 : p_head_q + 1'b1;
  assign i_head_inc = (32'(i_head_q) == 32'(INST_DEPTH - 1)) ? '0 : i_head_q + 1'b1;

  assign pop_inst = (action_q == ACT_ALLOC_INST);
  assign pop_ok   = pop_inst ? (i_fill_q != '0) : (p_fill_q != '0);

  // Select free list writes: init walk or push
  assign p_we    = (cmd_i.init_step && p_init_wr) || (cmd_i.load_free && push_p);
  assign i_we    = (cmd_i.init_step && i_init_wr) || (cmd_i.load_free && push_i);
  assign p_waddr = cmd_i.init_step ? idx_q[PPW-1:0] : p_tail;
  assign i_waddr = cmd_i.init_step ? idx_q[IPW-1:0] : i_tail;
  assign p_wdata = cmd_i.init_step ? p_ia_q : addr_q;
  assign i_wdata = cmd_i.init_step ? i_ia_q : addr_q;

  // Free list memories with registered head read
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    p_rd_q <= p_mem[p_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      i_mem[i_waddr] <= i_wdata;
    end
    i_rd_q <= i_mem[i_head_q];
  end

  // Capture the item and walk init addresses
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      addr_q   <= address_i;
      idx_q    <= '0;
      p_ia_q   <= p_start_q;
      i_ia_q   <= i_start_q;
    end else if (cmd_i.init_step) begin
      idx_q  <= idx_q + 1'b1;
      p_ia_q <= p_ia_q + ADDR_W'(p_size_q);
      i_ia_q <= i_ia_q + ADDR_W'(i_size_q);
    end
  end

  // Advance heads and fill levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q <= '0;
      p_fill_q <= '0;
      i_head_q <= '0;
      i_fill_q <= '0;
    end else if (cmd_i.load_init) begin
      p_head_q <= '0;
      p_fill_q <= p_n;
      i_head_q <= '0;
      i_fill_q <= i_n;
    end else if (cmd_i.load_pop && pop_ok) begin
      if (pop_inst) begin
        i_head_q <= i_head_inc;
        i_fill_q <= i_fill_q - 1'b1;
      end else begin
        p_head_q <= p_head_inc;
        p_fill_q <= p_fill_q - 1'b1;
      end
    end else if (cmd_i.load_free) begin
      if (push_p) begin
        p_fill_q <= p_fill_q + 1'b1;
      end
      if (push_i) begin
        i_fill_q <= i_fill_q + 1'b1;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_init) begin
      status_q <= STAT_OK;
      baddr_q  <= '0;
      size_q   <= '0;
      pool_q   <= 1'b0;
    end else if (cmd_i.load_pop) begin
      status_q <= pop_ok ? STAT_OK : STAT_EMPTY;
      baddr_q  <= pop_ok ? (pop_inst ? i_rd_q : p_rd_q) : '0;
      size_q   <= pop_ok ? (pop_inst ? i_size_q : ISIZE_W'(p_size_q)) : '0;
      pool_q   <= pop_inst;
    end else if (cmd_i.load_free) begin
      baddr_q <= '0;
      size_q  <= '0;
      if (in_p) begin
        status_q <= push_p ? STAT_OK : STAT_FULL;
        pool_q   <= 1'b0;
      end else if (in_i) begin
        status_q <= push_i ? STAT_OK : STAT_FULL;
        pool_q   <= 1'b1;
      end else begin
        status_q <= STAT_BAD_ADDR;
        pool_q   <= 1'b0;
      end
    end
  end

  assign status_o         = status_q;
  assign block_address_o  = baddr_q;
  assign alloc_size_o     = size_q;
  assign pool_o           = pool_q;

  // Fill levels stay within depth
  a_p_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(p_fill_q) <= 32'(POWER_DEPTH))
    else $error("power fill level above depth");

  a_i_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(i_fill_q) <= 32'(INST_DEPTH))
    else $error("instance fill level above depth");

  // A successful power pop lowers the power pool's fill by one
  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_pop && pop_ok && !pop_inst) |=> (p_fill_q == $past(p_fill_q) - 1'b1))
    else $error("power pop did not lower fill level");

  // A push never lands in both pools
  a_one_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_free |-> !(push_p && push_i))
    else $error("free pushed into both pools");

endmodule

`default_nettype wire

[src/two_pool_block_free_list_unit.sv]
// Two-pool block free list. The unit keeps a FIFO of free block addresses
// for a power pool and an instance pool and takes one transaction at a time.
// An allocate uses the head entry, which is read from the free-list memory
// into a register at the accepting edge and then loaded into the result
// register in the pop state. A free passes through a wait state and then a
// check state that loads its result; the wait lets the multiply-then-add
// pipeline that forms each pool's end address settle after a register write.
// An init writes min(count, depth) addresses into each pool, one memory
// write per pool per cycle, and its result becomes valid as the unit returns
// to idle. A waiting result does not stall the next acceptance; the unit
// stalls only when it must load a new result while the output still holds
// an untaken one. Registers are written through the cfg port; the user must
// write them only between transactions, as the block itself does not
// enforce this.

`default_nettype none

module two_pool_block_free_list_unit
  import tpbfl_pkg::*;
#(
  parameter int unsigned POWER_DEPTH = 64,
  parameter int unsigned INST_DEPTH  = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata from bit 0: action[1:0], address[33:2], zero fill
  input  wire [IN_W-1:0]       s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // tdata from bit 0: status[1:0], block_address[33:2],
  // alloc_size[58:34], pool[59], zero fill
  output logic [OUT_W-1:0]     m_axis_tdata
);

  tpbfl_cmd_t         cmd;
  tpbfl_stat_t        stat;
  tpbfl_action_e      action;
  tpbfl_status_e      status;
  logic [ADDR_W-1:0]  block_address;
  logic [ISIZE_W-1:0] alloc_size;
  logic               pool;

  assign action = tpbfl_action_e'(s_axis_tdata[ACTION_W-1:0]);

  tpbfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (action),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tpbfl_datapath #(
    .POWER_DEPTH (POWER_DEPTH),
    .INST_DEPTH  (INST_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action),
    .address_i        (s_axis_tdata[ACTION_W+ADDR_W-1:ACTION_W]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status),
    .block_address_o  (block_address),
    .alloc_size_o     (alloc_size),
    .pool_o           (pool)
  );

  // Pack the result fields
  assign m_axis_tdata = {(OUT_W-STATUS_W-ADDR_W-ISIZE_W-1)'(0), pool, alloc_size,
                         block_address, status};

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  import tpbfl_pkg::*;

  localparam int unsigned POOL_DEPTH      = 64;
  localparam int unsigned PHASE_ITEMS     = 89;
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned FILL_W          = IN_W - ADDR_W - ACTION_W;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One result transaction, first field in the lowest bits
  typedef struct packed {
    logic                pool;
    logic [ISIZE_W-1:0]  size;
    logic [ADDR_W-1:0]   addr;
    tpbfl_status_e       status;
  } result_t;

  // One directed row: the request and, where obvious, its typed result
  typedef struct packed {
    tpbfl_action_e      act;
    logic [ADDR_W-1:0]  addr;
    logic               typed;
    result_t            res;
  } dir_row_t;

  typedef struct {
    logic [ADDR_W-1:0]  start;
    logic [ISIZE_W-1:0] size;
    logic [COUNT_W-1:0] count;
  } pool_set_t;

  // Reset config: power range [0, 16M), instance range [0, 4M)
  localparam dir_row_t DIR_TABLE [16] = '{
    '{ACT_ALLOC_POWER, 32'h0000_0000, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_EMPTY}},
    '{ACT_ALLOC_INST,  32'h0000_0000, 1'b1, '{1'b1, 25'd0, 32'd0, STAT_EMPTY}},
    '{ACT_FREE,        32'hFFFF_FFFF, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_BAD_ADDR}},
    '{ACT_FREE,        32'h0000_0000, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_OK}},
    '{ACT_ALLOC_POWER, 32'h0000_0000, 1'b1, '{1'b0, 25'd262144, 32'd0, STAT_OK}},
    '{ACT_INIT,        32'hFFFF_FFFF, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_OK}},
    '{ACT_ALLOC_POWER, 32'h0000_0000, 1'b1, '{1'b0, 25'd262144, 32'd0, STAT_OK}},
    '{ACT_ALLOC_POWER, 32'h0000_0000, 1'b0, '0},
    '{ACT_ALLOC_INST,  32'h0000_0000, 1'b1, '{1'b1, 25'd65536, 32'd0, STAT_OK}},
    '{ACT_ALLOC_INST,  32'h0000_0000, 1'b0, '0},
    '{ACT_FREE,        32'h00FF_FFFF, 1'b0, '0},
    '{ACT_FREE,        32'h0100_0000, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_BAD_ADDR}},
    '{ACT_FREE,        32'h0000_0004, 1'b0, '0},
    '{ACT_FREE,        32'h0000_0008, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_FULL}},
    '{ACT_INIT,        32'h0000_0000, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_OK}},
    '{ACT_FREE,        32'h0000_0010, 1'b1, '{1'b0, 25'd0, 32'd0, STAT_FULL}}
  };

  // Fixed register sets, in index order; later phases draw random values
  localparam logic [CFG_W-1:0] CFG_SETS [4][6] = '{
    '{32'h0000_1000, 32'h0000_0100, 32'd8,   32'h0010_0000, 32'h0000_0040, 32'd12},
    '{32'h0000_0000, 32'h0000_0001, 32'd64,  32'hFFFF_FFC0, 32'h0000_0020, 32'd4},
    '{32'hFFFF_F000, 32'h0007_FFFF, 32'd127, 32'h8000_0000, 32'h0000_0000, 32'd5},
    '{32'hFFFF_FFFF, 32'h0000_1234, 32'd0,   32'h0200_0000, 32'h01FF_FFFF, 32'd64}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  // Predictor state
  pool_set_t            pool_cfg [2];
  logic [ADDR_W-1:0]    free_mem [2][POOL_DEPTH];
  int unsigned          rd_ptr [2];
  int unsigned          fill_lvl [2];

  result_t              pending_results [$];
  logic [ADDR_W-1:0]    held_blocks [$];
  int                   mismatches  = 0;
  int                   tx_idle_pct = 30;
  int                   rx_idle_pct = 58;
  logic                 hold_req    = 1'b0;
  logic                 hold_done   = 1'b0;
  int unsigned          stall_cnt   = 0;

  two_pool_block_free_list_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Range test without wrap: start <= a < start + count*size
  function automatic logic addr_in_pool(int p, logic [ADDR_W-1:0] a);
    logic [63:0] lim;
    lim = 64'(pool_cfg[p].start) + 64'(pool_cfg[p].count) * 64'(pool_cfg[p].size);
    return (64'(a) >= 64'(pool_cfg[p].start)) && (64'(a) < lim);
  endfunction

  // Advance the free lists by one request and return its result
  function automatic result_t predict_result(tpbfl_action_e act, logic [ADDR_W-1:0] a);
    result_t           r;
    int                p;
    int unsigned       n;
    logic [ADDR_W-1:0] walk;
    r = '{1'b0, '0, '0, STAT_OK};
    case (act)
      ACT_INIT: begin
        for (p = 0; p < 2; p++) begin
          n = (pool_cfg[p].count < POOL_DEPTH) ? pool_cfg[p].count : POOL_DEPTH;
          walk = pool_cfg[p].start;
          for (int i = 0; i < n; i++) begin
            free_mem[p][i] = walk;
            walk += ADDR_W'(pool_cfg[p].size);
          end
          rd_ptr[p] = 0;
          fill_lvl[p] = n;
        end
      end
      ACT_ALLOC_POWER, ACT_ALLOC_INST: begin
        p = (act == ACT_ALLOC_INST) ? 1 : 0;
        r.pool = p[0];
        if (fill_lvl[p] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.addr = free_mem[p][rd_ptr[p]];
          r.size = pool_cfg[p].size;
          rd_ptr[p] = (rd_ptr[p] + 1) % POOL_DEPTH;
          fill_lvl[p]--;
        end
      end
      default: begin
        if (addr_in_pool(0, a)) p = 0;
        else if (addr_in_pool(1, a)) p = 1;
        else p = -1;
        if (p < 0) begin
          r.status = STAT_BAD_ADDR;
        end else begin
          r.pool = p[0];
          if (fill_lvl[p] >= POOL_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            free_mem[p][(rd_ptr[p] + fill_lvl[p]) % POOL_DEPTH] = a;
            fill_lvl[p]++;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Write one register while the unit is idle and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_POWER_START: pool_cfg[0].start = val;
      REG_POWER_SIZE:  pool_cfg[0].size  = ISIZE_W'(val[PSIZE_W-1:0]);
      REG_POWER_COUNT: pool_cfg[0].count = val[COUNT_W-1:0];
      REG_INST_START:  pool_cfg[1].start = val;
      REG_INST_SIZE:   pool_cfg[1].size  = val[ISIZE_W-1:0];
      REG_INST_COUNT:  pool_cfg[1].count = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one request transaction, wait for it to be taken, queue its result
  task automatic send_request(input tpbfl_action_e act, input logic [ADDR_W-1:0] a,
                              input logic typed, input result_t typed_res,
                              output result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{FILL_W{1'b0}}, a, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_result(act, a);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and wait until every queued result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly alloc/free traffic on live blocks, plus range edges and noise
  task automatic rand_request(output tpbfl_action_e act, output logic [ADDR_W-1:0] a);
    int          pick;
    int          p;
    int          idx;
    logic [63:0] span;
    logic [ADDR_W-1:0] lim;
    pick = $urandom_range(99);
    a = $urandom;
    if (pick < 2) act = ACT_INIT;
    else if (pick < 34) act = ACT_ALLOC_POWER;
    else if (pick < 58) act = ACT_ALLOC_INST;
    else begin
      act  = ACT_FREE;
      pick = $urandom_range(99);
      p    = $urandom_range(1);
      span = 64'(pool_cfg[p].count) * 64'(pool_cfg[p].size);
      lim  = ADDR_W'(64'(pool_cfg[p].start) + span);
      if (pick < 55 && held_blocks.size() > 0) begin
        idx = $urandom_range(held_blocks.size() - 1);
        a = held_blocks[idx];
        held_blocks.delete(idx);
      end else if (pick < 75) begin
        a = pool_cfg[p].start + ((span == 0) ? '0 : ADDR_W'(64'($urandom) % span));
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0: a = pool_cfg[p].start;
          1: a = pool_cfg[p].start - 1;
          2: a = lim - 1;
          default: a = lim;
        endcase
      end
    end
  endtask

  // Stimulus: reset, directed table, then randomized phases
  initial begin : stimulus
    tpbfl_action_e     act;
    logic [ADDR_W-1:0] a;
    result_t           res;
    logic [CFG_W-1:0]  regs [6];

    pool_cfg[0] = '{RST_POWER_START, ISIZE_W'(RST_POWER_SIZE), RST_POWER_COUNT};
    pool_cfg[1] = '{RST_INST_START, RST_INST_SIZE, RST_INST_COUNT};
    rd_ptr   = '{0, 0};
    fill_lvl = '{0, 0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TABLE[i])
      send_request(DIR_TABLE[i].act, DIR_TABLE[i].addr, DIR_TABLE[i].typed,
                   DIR_TABLE[i].res, res);

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      tx_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 58 : 0;
      rx_idle_pct = (phase < 2) ? 58 : (phase < 4) ? 30 : 0;
      for (int r = 0; r < 6; r++)
        regs[r] = (phase < 4) ? CFG_SETS[phase][r] : $urandom;
      if (phase == 5) begin
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
      end
      write_reg(REG_POWER_START, regs[0]);
      write_reg(REG_POWER_SIZE,  regs[1]);
      write_reg(REG_POWER_COUNT, regs[2]);
      write_reg(REG_INST_START,  regs[3]);
      write_reg(REG_INST_SIZE,   regs[4]);
      write_reg(REG_INST_COUNT,  regs[5]);
      held_blocks.delete();
      send_request(ACT_INIT, $urandom, 1'b0, '0, res);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rand_request(act, a);
        send_request(act, a, 1'b0, '0, res);
        if (act == ACT_INIT) held_blocks.delete();
        else if (act != ACT_FREE && res.status == STAT_OK && held_blocks.size() < 128)
          held_blocks.push_back(res.addr);
        if (phase == 0 && n == 30) hold_req <= 1'b1;
      end
    end
    drain_results();

    if (mismatches == 0) begin
      $display("two_pool_block_free_list_unit test passed");
    end else begin
      $display("two_pool_block_free_list_unit test failed");
    end
    $finish;
  end

  // Result ready: random idling, plus one long hold-off to back up the input
  initial begin : result_ready
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transaction with the oldest queued result
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.addr !== want.addr) begin
          $display("%0t: block_address expected %h got %h", $time, want.addr, got.addr);
          mismatches++;
        end
        if (got.size !== want.size) begin
          $display("%0t: alloc_size expected %0d got %0d", $time, want.size, got.size);
          mismatches++;
        end
        if (got.pool !== want.pool) begin
          $display("%0t: pool expected %0d got %0d", $time, want.pool, got.pool);
          mismatches++;
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("two_pool_block_free_list_unit test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
